>>> rtl/core/bvse_pkg.sv
// Shared widths, defaults and command codes of the bit vector set engine.
`default_nettype none

package bvse_pkg;

   localparam int NumWordsDefault = 16;
   localparam int WordBitsDefault = 64;

   localparam int CmdW     = 4;
   localparam int IdxW     = 4;
   localparam int DataW    = 64;
   localparam int LenW     = 11;
   localparam int NextBitW = 10;

   localparam logic [LenW-1:0] LenReset = 11'd1024;

   typedef enum logic [CmdW-1:0] {
      CMD_LOAD         = 4'd0,
      CMD_UNION        = 4'd1,
      CMD_DIFFERENCE   = 4'd2,
      CMD_GEN_KILL     = 4'd3,
      CMD_INTERSECT    = 4'd4,
      CMD_COMPARE      = 4'd5,
      CMD_TEST_EMPTY   = 4'd6,
      CMD_READ         = 4'd7,
      CMD_ITER_RESTART = 4'd8,
      CMD_ITER_NEXT    = 4'd9
   } command_type;

endpackage

`default_nettype wire

>>> rtl/core/bvse_if.sv
// Request and response channel interfaces of the bit vector set engine.
`default_nettype none

interface bvse_req_if;
   logic                          valid;
   logic                          ready;
   logic [bvse_pkg::CmdW-1:0]     command;
   logic [bvse_pkg::IdxW-1:0]     word_index;
   logic [bvse_pkg::DataW-1:0]    operand_word;
   logic [bvse_pkg::DataW-1:0]    kill_word;
   logic [bvse_pkg::LenW-1:0]     other_length;

   modport source (
      output valid, command, word_index, operand_word, kill_word, other_length,
      input  ready
   );
   modport sink (
      input  valid, command, word_index, operand_word, kill_word, other_length,
      output ready
   );
endinterface

interface bvse_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [bvse_pkg::DataW-1:0]     read_data;
   logic                           changed;
   logic                           equal;
   logic                           nonempty;
   logic [bvse_pkg::NextBitW-1:0]  next_bit;
   logic                           iter_done;

   modport source (
      output valid, read_data, changed, equal, nonempty, next_bit, iter_done,
      input  ready
   );
   modport sink (
      input  valid, read_data, changed, equal, nonempty, next_bit, iter_done,
      output ready
   );
endinterface

`default_nettype wire

>>> rtl/core/bit_vector_set_engine.sv
// Bit vector set engine: word-wise set operations over a bit set held in one memory.
//
// Usage:
//   req_ch carries one command per transfer (load, union, difference, gen/kill,
//   intersect, compare, test_empty, read, iter_restart, iter_next) addressed by
//   word_index. rsp_ch returns exactly one result per request: the stored word at
//   word_index after the command, the accumulated changed/equal/nonempty flags and
//   the iterator result. csr_wr_en/csr_wr_data set the vector length in bits;
//   write it only while no request is in flight.
// Sequencing:
//   One request is processed at a time. Word commands take one read-modify-write
//   of the set memory: the word is read when the request is taken, and the write
//   and the registered response follow together. iter_next reads the word at
//   word_index, splits the iterator position into word and bit, then scans one
//   word at a time, reading and then testing it, until a set bit or the vector end.
// Reset:
//   Clears the flags (equal set), the iterator position and the response valid, and
//   sets the vector length to 1024. The set memory is not cleared.
// Stalls:
//   The response sits in an output register. A new request is taken while it waits;
//   the engine then holds its finished result until the output register frees up.
`default_nettype none

module bit_vector_set_engine #(
   parameter int NUM_WORDS = bvse_pkg::NumWordsDefault,
   parameter int WORD_BITS = bvse_pkg::WordBitsDefault
) (
   input  logic                      clock,
   input  logic                      reset,
   bvse_req_if.sink                  req_ch,
   bvse_rsp_if.source                rsp_ch,
   input  logic                      csr_wr_en,
   input  logic [bvse_pkg::LenW-1:0] csr_wr_data
);

   localparam int DataW    = bvse_pkg::DataW;
   localparam int LenW     = bvse_pkg::LenW;
   localparam int IdxW     = bvse_pkg::IdxW;
   localparam int NextBitW = bvse_pkg::NextBitW;
   localparam int AddrW    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int BitW     = $clog2(WORD_BITS);
   localparam int BaseW    = LenW + 1;
   localparam int MaxBits  = NUM_WORDS * WORD_BITS;
   localparam int LenMax   = (1 << LenW) - 1;
   localparam int LenCap   = (MaxBits > LenMax) ? LenMax : MaxBits;
   localparam int Shift    = 16;
   localparam int Recip    = (1 << Shift) / WORD_BITS;
   localparam int ProdW    = LenW + Shift + 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_DIV,
      S_FIX,
      S_SCAN_RD,
      S_SCAN_EV,
      S_DONE
   } state_type;

   localparam logic [WORD_BITS-1:0] Ones = '1;

   // set memory
   logic [WORD_BITS-1:0] mem [NUM_WORDS];
   logic                 mem_we;
   logic                 mem_re;
   logic [AddrW-1:0]     wr_addr;
   logic [AddrW-1:0]     rd_addr;
   logic [WORD_BITS-1:0] wr_data;
   logic [WORD_BITS-1:0] rd_data_ff;

   // control state
   state_type            state_ff, state_in;
   logic                 changed_ff, changed_in;
   logic                 equal_ff, equal_in;
   logic                 nonempty_ff, nonempty_in;
   logic [LenW-1:0]      pos_ff, pos_in;
   logic [LenW-1:0]      len_ff, len_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // captured request and working registers
   bvse_pkg::command_type cmd_ff, cmd_in;
   logic [IdxW-1:0]      idx_ff, idx_in;
   logic [WORD_BITS-1:0] opw_ff, opw_in;
   logic [WORD_BITS-1:0] kill_ff, kill_in;
   logic [LenW-1:0]      olen_ff, olen_in;
   logic [WORD_BITS-1:0] keep_ff, keep_in;
   logic [LenW-1:0]      q_ff, q_in;
   logic [AddrW-1:0]     scan_word_ff, scan_word_in;
   logic [BitW-1:0]      bit_ff, bit_in;
   logic [BaseW-1:0]     base_ff, base_in;
   logic [NextBitW-1:0]  iter_bit_ff, iter_bit_in;
   logic                 iter_done_ff, iter_done_in;

   // response register
   logic [DataW-1:0]     rsp_data_ff, rsp_data_in;
   logic                 rsp_changed_ff, rsp_changed_in;
   logic                 rsp_equal_ff, rsp_equal_in;
   logic                 rsp_nonempty_ff, rsp_nonempty_in;
   logic [NextBitW-1:0]  rsp_next_bit_ff, rsp_next_bit_in;
   logic                 rsp_iter_done_ff, rsp_iter_done_in;

   // combinational helpers
   logic                 accept;
   logic                 out_free;
   logic [LenW-1:0]      len_eff;
   logic [BaseW-1:0]     len_wide;
   logic [BaseW-1:0]     word_base;
   logic                 in_range;
   logic                 active;
   logic                 last_word;
   logic [BaseW-1:0]     rem;
   logic [WORD_BITS-1:0] cmp_mask;
   logic                 clr;
   logic [WORD_BITS-1:0] after;
   logic                 fl_changed;
   logic                 fl_equal;
   logic                 fl_nonempty;
   logic [LenW-1:0]      fix_q;
   logic [BaseW-1:0]     fix_base;
   logic [BaseW-1:0]     fix_rem;
   logic [BaseW-1:0]     lim;
   logic [WORD_BITS-1:0] hi_mask;
   logic [WORD_BITS-1:0] hits;
   logic [BitW-1:0]      enc;
   logic [BaseW-1:0]     hit_pos;
   logic [BaseW-1:0]     next_base;

   assign accept    = req_ch.valid && (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.read_data   = rsp_data_ff;
   assign rsp_ch.changed     = rsp_changed_ff;
   assign rsp_ch.equal       = rsp_equal_ff;
   assign rsp_ch.nonempty    = rsp_nonempty_ff;
   assign rsp_ch.next_bit    = rsp_next_bit_ff;
   assign rsp_ch.iter_done   = rsp_iter_done_ff;

   // clamp the configured length to 1 .. set capacity
   always_comb begin
      if (len_ff == '0) begin
         len_eff = LenW'(1);
      end else if (32'(len_ff) > LenCap) begin
         len_eff = LenW'(LenCap);
      end else begin
         len_eff = len_ff;
      end
   end

   assign len_wide  = BaseW'(len_eff);
   assign word_base = BaseW'(32'(idx_ff) * WORD_BITS);
   assign in_range  = 32'(idx_ff) < NUM_WORDS;
   assign active    = word_base < len_wide;
   assign last_word = active && ((word_base + BaseW'(WORD_BITS)) >= len_wide);
   assign rem       = len_wide - word_base;
   assign cmp_mask  = last_word ? (Ones >> (BaseW'(WORD_BITS) - rem)) : Ones;
   assign clr       = (cmd_ff <= bvse_pkg::CMD_READ) && (idx_ff == '0);

   // word-at-position split: quotient estimate is exact or one low
   always_comb begin
      fix_base = BaseW'(32'(q_ff) * WORD_BITS);
      fix_rem  = BaseW'(pos_ff) - fix_base;
      fix_q    = q_ff;
      if (fix_rem >= BaseW'(WORD_BITS)) begin
         fix_q    = q_ff + LenW'(1);
         fix_base = fix_base + BaseW'(WORD_BITS);
         fix_rem  = fix_rem - BaseW'(WORD_BITS);
      end
   end

   // scan of one stored word: bits from bit_ff up to the vector end
   assign lim       = len_wide - base_ff;
   assign hi_mask   = (lim >= BaseW'(WORD_BITS)) ? Ones
                                                 : (Ones >> (BaseW'(WORD_BITS) - lim));
   assign hits      = rd_data_ff & (Ones << bit_ff) & hi_mask;
   assign hit_pos   = base_ff + BaseW'(enc);
   assign next_base = base_ff + BaseW'(WORD_BITS);

   always_comb begin
      enc = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (hits[i]) begin
            enc = BitW'(i);
         end
      end
   end

   // word command: modify and flag update
   always_comb begin
      fl_changed  = clr ? 1'b0 : changed_ff;
      fl_equal    = clr ? 1'b1 : equal_ff;
      fl_nonempty = clr ? 1'b0 : nonempty_ff;
      after       = rd_data_ff;
      mem_we      = 1'b0;
      if (active) begin
         case (cmd_ff)
            bvse_pkg::CMD_LOAD: begin
               after  = opw_ff;
               mem_we = 1'b1;
            end
            bvse_pkg::CMD_UNION: begin
               after  = rd_data_ff | opw_ff;
               mem_we = 1'b1;
            end
            bvse_pkg::CMD_DIFFERENCE: begin
               after  = rd_data_ff & ~opw_ff;
               mem_we = 1'b1;
            end
            bvse_pkg::CMD_GEN_KILL: begin
               after  = rd_data_ff | (opw_ff & ~kill_ff);
               mem_we = 1'b1;
            end
            bvse_pkg::CMD_INTERSECT: begin
               after  = rd_data_ff & opw_ff;
               mem_we = 1'b1;
            end
            bvse_pkg::CMD_COMPARE: begin
               if ((olen_ff != len_eff) || ((rd_data_ff & cmp_mask) != (opw_ff & cmp_mask))) begin
                  fl_equal = 1'b0;
               end
            end
            bvse_pkg::CMD_TEST_EMPTY: begin
               if (rd_data_ff != '0) begin
                  fl_nonempty = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
      if (((cmd_ff == bvse_pkg::CMD_UNION) || (cmd_ff == bvse_pkg::CMD_DIFFERENCE) ||
           (cmd_ff == bvse_pkg::CMD_GEN_KILL)) && (after != rd_data_ff)) begin
         fl_changed = 1'b1;
      end
   end

   // next-state logic
   always_comb begin
      state_in         = state_ff;
      changed_in       = changed_ff;
      equal_in         = equal_ff;
      nonempty_in      = nonempty_ff;
      pos_in           = pos_ff;
      len_in           = csr_wr_en ? csr_wr_data : len_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ch.ready;
      cmd_in           = cmd_ff;
      idx_in           = idx_ff;
      opw_in           = opw_ff;
      kill_in          = kill_ff;
      olen_in          = olen_ff;
      keep_in          = keep_ff;
      q_in             = q_ff;
      scan_word_in     = scan_word_ff;
      bit_in           = bit_ff;
      base_in          = base_ff;
      iter_bit_in      = iter_bit_ff;
      iter_done_in     = iter_done_ff;
      rsp_data_in      = rsp_data_ff;
      rsp_changed_in   = rsp_changed_ff;
      rsp_equal_in     = rsp_equal_ff;
      rsp_nonempty_in  = rsp_nonempty_ff;
      rsp_next_bit_in  = rsp_next_bit_ff;
      rsp_iter_done_in = rsp_iter_done_ff;
      mem_re           = 1'b0;
      rd_addr          = scan_word_ff;
      wr_addr          = AddrW'(32'(idx_ff));
      wr_data          = after;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in   = bvse_pkg::command_type'(req_ch.command);
               idx_in   = req_ch.word_index;
               opw_in   = req_ch.operand_word[WORD_BITS-1:0];
               kill_in  = req_ch.kill_word[WORD_BITS-1:0];
               olen_in  = req_ch.other_length;
               mem_re   = 1'b1;
               rd_addr  = AddrW'(32'(req_ch.word_index));
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (cmd_ff == bvse_pkg::CMD_ITER_NEXT) begin
               keep_in  = in_range ? rd_data_ff : '0;
               state_in = S_DIV;
            end else if (out_free) begin
               changed_in       = fl_changed;
               equal_in         = fl_equal;
               nonempty_in      = fl_nonempty;
               if (cmd_ff == bvse_pkg::CMD_ITER_RESTART) begin
                  pos_in = '0;
               end
               rsp_valid_in     = 1'b1;
               rsp_data_in      = in_range ? DataW'(after) : '0;
               rsp_changed_in   = fl_changed;
               rsp_equal_in     = fl_equal;
               rsp_nonempty_in  = fl_nonempty;
               rsp_next_bit_in  = '0;
               rsp_iter_done_in = 1'b0;
               state_in         = S_IDLE;
            end
         end
         S_DIV: begin
            if (pos_ff >= len_eff) begin
               pos_in       = len_eff;
               iter_bit_in  = '0;
               iter_done_in = 1'b1;
               state_in     = S_DONE;
            end else begin
               q_in     = LenW'((ProdW'(pos_ff) * ProdW'(Recip)) >> Shift);
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            scan_word_in = AddrW'(fix_q);
            base_in      = fix_base;
            bit_in       = BitW'(fix_rem);
            state_in     = S_SCAN_RD;
         end
         S_SCAN_RD: begin
            mem_re   = 1'b1;
            state_in = S_SCAN_EV;
         end
         S_SCAN_EV: begin
            if (hits != '0) begin
               iter_bit_in  = NextBitW'(hit_pos);
               iter_done_in = 1'b0;
               pos_in       = LenW'(hit_pos + BaseW'(1));
               state_in     = S_DONE;
            end else if (next_base >= len_wide) begin
               iter_bit_in  = '0;
               iter_done_in = 1'b1;
               pos_in       = len_eff;
               state_in     = S_DONE;
            end else begin
               scan_word_in = scan_word_ff + AddrW'(1);
               bit_in       = '0;
               base_in      = next_base;
               state_in     = S_SCAN_RD;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_data_in      = DataW'(keep_ff);
               rsp_changed_in   = changed_ff;
               rsp_equal_in     = equal_ff;
               rsp_nonempty_in  = nonempty_ff;
               rsp_next_bit_in  = iter_bit_ff;
               rsp_iter_done_in = iter_done_ff;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // write only on the completing cycle of a word command
   logic mem_wr_go;
   assign mem_wr_go = mem_we && (state_ff == S_EXEC) && out_free &&
                      (cmd_ff != bvse_pkg::CMD_ITER_NEXT);

   always_ff @(posedge clock) begin
      if (mem_wr_go) begin
         mem[wr_addr] <= wr_data;
      end
      if (mem_re) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         changed_ff   <= 1'b0;
         equal_ff     <= 1'b1;
         nonempty_ff  <= 1'b0;
         pos_ff       <= '0;
         len_ff       <= bvse_pkg::LenReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         changed_ff   <= changed_in;
         equal_ff     <= equal_in;
         nonempty_ff  <= nonempty_in;
         pos_ff       <= pos_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff           <= cmd_in;
      idx_ff           <= idx_in;
      opw_ff           <= opw_in;
      kill_ff          <= kill_in;
      olen_ff          <= olen_in;
      keep_ff          <= keep_in;
      q_ff             <= q_in;
      scan_word_ff     <= scan_word_in;
      bit_ff           <= bit_in;
      base_ff          <= base_in;
      iter_bit_ff      <= iter_bit_in;
      iter_done_ff     <= iter_done_in;
      rsp_data_ff      <= rsp_data_in;
      rsp_changed_ff   <= rsp_changed_in;
      rsp_equal_ff     <= rsp_equal_in;
      rsp_nonempty_ff  <= rsp_nonempty_in;
      rsp_next_bit_ff  <= rsp_next_bit_in;
      rsp_iter_done_ff <= rsp_iter_done_in;
   end

endmodule

`default_nettype wire

>>> rtl/core/bvse_checker.sv
// Port-level assertions of the bit vector set engine and their bind.
`default_nettype none

module bvse_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [bvse_pkg::DataW-1:0]    rsp_read_data,
   input logic                          rsp_changed,
   input logic                          rsp_equal,
   input logic                          rsp_nonempty,
   input logic [bvse_pkg::NextBitW-1:0] rsp_next_bit,
   input logic                          rsp_iter_done
);

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data) &&
      $stable(rsp_changed) && $stable(rsp_equal) && $stable(rsp_nonempty) &&
      $stable(rsp_next_bit) && $stable(rsp_iter_done))
      else $error("response changed while stalled");

   // one request in flight: the engine is busy right after a transfer
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a previous one is in flight");

   // a new response only comes from a cycle in which the engine was busy
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response appeared without work in progress");

   // exhausted iterator reports bit zero
   a_done_bit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_iter_done |-> rsp_next_bit == '0)
      else $error("iterator done with nonzero bit index");

endmodule

bind bit_vector_set_engine bvse_checker u_bvse_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_read_data (rsp_ch.read_data),
   .rsp_changed   (rsp_ch.changed),
   .rsp_equal     (rsp_ch.equal),
   .rsp_nonempty  (rsp_ch.nonempty),
   .rsp_next_bit  (rsp_ch.next_bit),
   .rsp_iter_done (rsp_ch.iter_done)
);

`default_nettype wire

>>> test/tb_bit_vector_set_engine.sv
// Self-checking testbench for the bit vector set engine: predicted results, random traffic.
`timescale 1ns / 1ps

module tb_bit_vector_set_engine;

   localparam int CmdW     = bvse_pkg::CmdW;
   localparam int IdxW     = bvse_pkg::IdxW;
   localparam int DataW    = bvse_pkg::DataW;
   localparam int LenW     = bvse_pkg::LenW;
   localparam int NextBitW = bvse_pkg::NextBitW;
   localparam int NumWords = bvse_pkg::NumWordsDefault;
   localparam int WordBits = bvse_pkg::WordBitsDefault;
   localparam int unsigned MaxBits = NumWords * WordBits;
   localparam logic [LenW-1:0] LenReset = bvse_pkg::LenReset;
   localparam logic [DataW-1:0] WordMask = {DataW{1'b1}} >> (DataW - WordBits);
   localparam logic [DataW-1:0] WordOne = {{(DataW-1){1'b0}}, 1'b1};
   localparam int ResetCycles = 12;
   localparam int MaxReports = 10;
   localparam int LongHold = 200;
   localparam int TailCycles = 50;
   localparam int PhaseItems = 213;
   localparam int unsigned CycleLimit = 600000;

   typedef struct {
      logic [DataW-1:0]    read_data;
      logic                changed;
      logic                equal;
      logic                nonempty;
      logic [NextBitW-1:0] next_bit;
      logic                iter_done;
   } set_result_type;

   // Tracks the stored set, flags and iterator; holds the results still due.
   class bitset_tracker_type;
      logic [DataW-1:0] words [NumWords];
      bit               changed_flag;
      bit               equal_flag;
      bit               nonempty_flag;
      int unsigned      iter_pos;
      int unsigned      length;
      set_result_type   due_results [$];
      int unsigned      failures;

      function new();
         foreach (words[i]) words[i] = '0;
         changed_flag  = 1'b0;
         equal_flag    = 1'b1;
         nonempty_flag = 1'b0;
         iter_pos      = 0;
         length        = LenReset;
         failures      = 0;
      endfunction

      function int unsigned eff_length();
         if (length < 1) return 1;
         if (length > MaxBits) return MaxBits;
         return length;
      endfunction

      function int unsigned active_words();
         return (eff_length() + WordBits - 1) / WordBits;
      endfunction

      // Valid bits of word idx: only the last active word is cut short.
      function logic [DataW-1:0] valid_mask(int unsigned idx);
         int unsigned rem;
         if (idx != active_words() - 1) return WordMask;
         rem = eff_length() - (active_words() - 1) * WordBits;
         return WordMask >> (WordBits - rem);
      endfunction

      function void flag_failure(string msg);
         failures++;
         if (failures <= MaxReports) $display("%s", msg);
      endfunction

      function void note_command(logic [CmdW-1:0] cmd, logic [IdxW-1:0] idx,
                                 logic [DataW-1:0] opw, logic [DataW-1:0] kill,
                                 logic [LenW-1:0] olen);
         set_result_type   want;
         logic [DataW-1:0] old_word;
         logic [DataW-1:0] after;
         logic [DataW-1:0] m;
         int unsigned      len;
         int unsigned      aw;
         int unsigned      p;
         bit               found;
         len = eff_length();
         aw  = active_words();
         opw  = opw & WordMask;
         kill = kill & WordMask;
         want.next_bit  = '0;
         want.iter_done = 1'b0;

         if (cmd <= bvse_pkg::CMD_READ && idx == 0) begin
            changed_flag  = 1'b0;
            equal_flag    = 1'b1;
            nonempty_flag = 1'b0;
         end

         if (cmd <= bvse_pkg::CMD_TEST_EMPTY && idx < aw && idx < NumWords) begin
            old_word = words[idx];
            after    = old_word;
            case (cmd)
               bvse_pkg::CMD_LOAD:       after = opw;
               bvse_pkg::CMD_UNION:      after = old_word | opw;
               bvse_pkg::CMD_DIFFERENCE: after = old_word & ~opw;
               bvse_pkg::CMD_GEN_KILL:   after = old_word | (opw & ~kill);
               bvse_pkg::CMD_INTERSECT:  after = old_word & opw;
               bvse_pkg::CMD_COMPARE: begin
                  m = valid_mask(idx);
                  if (olen != len || (old_word & m) != (opw & m)) equal_flag = 1'b0;
               end
               bvse_pkg::CMD_TEST_EMPTY: begin
                  if (old_word != '0) nonempty_flag = 1'b1;
               end
               default: ;
            endcase
            if ((cmd == bvse_pkg::CMD_UNION || cmd == bvse_pkg::CMD_DIFFERENCE ||
                 cmd == bvse_pkg::CMD_GEN_KILL) && after != old_word)
               changed_flag = 1'b1;
            words[idx] = after & WordMask;
         end else if (cmd == bvse_pkg::CMD_ITER_RESTART) begin
            iter_pos = 0;
         end else if (cmd == bvse_pkg::CMD_ITER_NEXT) begin
            p = iter_pos;
            found = 1'b0;
            while (p < len && !found) begin
               if (words[p / WordBits][p % WordBits]) found = 1'b1;
               else p++;
            end
            if (found) begin
               want.next_bit = NextBitW'(p);
               iter_pos = p + 1;
            end else begin
               want.iter_done = 1'b1;
               iter_pos = len;
            end
         end

         want.read_data = words[idx];
         want.changed   = changed_flag;
         want.equal     = equal_flag;
         want.nonempty  = nonempty_flag;
         due_results.push_back(want);
      endfunction

      function void check_result(set_result_type got);
         set_result_type want;
         if (due_results.size() == 0) begin
            flag_failure($sformatf("unexpected result: data=%h chg=%b eq=%b ne=%b bit=%0d done=%b",
                                   got.read_data, got.changed, got.equal, got.nonempty,
                                   got.next_bit, got.iter_done));
            return;
         end
         want = due_results.pop_front();
         if (got.read_data !== want.read_data || got.changed !== want.changed ||
             got.equal !== want.equal || got.nonempty !== want.nonempty ||
             got.next_bit !== want.next_bit || got.iter_done !== want.iter_done)
            flag_failure($sformatf({"result mismatch: expected data=%h chg=%b eq=%b ne=%b ",
                                    "bit=%0d done=%b, got data=%h chg=%b eq=%b ne=%b ",
                                    "bit=%0d done=%b"},
                                   want.read_data, want.changed, want.equal, want.nonempty,
                                   want.next_bit, want.iter_done,
                                   got.read_data, got.changed, got.equal, got.nonempty,
                                   got.next_bit, got.iter_done));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [LenW-1:0] csr_wr_data = '0;

   bvse_req_if req_ch ();
   bvse_rsp_if rsp_ch ();

   bitset_tracker_type tracker = new();

   bit          idle_on = 1'b1;
   int unsigned items_sent = 0;
   int unsigned long_hold_requests = 0;
   int unsigned long_holds_done = 0;
   int unsigned phase_lengths [9] = '{1, 65, 1024, 7, 1023, 64, 700, 128, 1024};

   bit_vector_set_engine i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [DataW-1:0] rand_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return WordMask;
         2: return WordOne << $urandom_range(0, WordBits - 1);
         3: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [LenW-1:0] rand_len();
      return LenW'($urandom_range(1, MaxBits));
   endfunction

   task automatic send_item(input logic [CmdW-1:0] cmd, input int unsigned idx,
                            input logic [DataW-1:0] opw, input logic [DataW-1:0] kill,
                            input logic [LenW-1:0] olen);
      int unsigned gap;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 8);
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid        <= 1'b1;
      req_ch.command      <= cmd;
      req_ch.word_index   <= IdxW'(idx);
      req_ch.operand_word <= opw;
      req_ch.kill_word    <= kill;
      req_ch.other_length <= olen;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      tracker.note_command(cmd, IdxW'(idx), opw, kill, olen);
      items_sent++;
   endtask

   // Restart, then step until the end of the set is reached and one more for done.
   task automatic iter_walk(input int unsigned max_nexts);
      int unsigned n;
      send_item(bvse_pkg::CMD_ITER_RESTART, $urandom_range(0, NumWords - 1), rand_word(),
                rand_word(), rand_len());
      n = 0;
      while (n < max_nexts && tracker.iter_pos < tracker.eff_length()) begin
         send_item(bvse_pkg::CMD_ITER_NEXT, $urandom_range(0, NumWords - 1), rand_word(),
                   rand_word(), rand_len());
         n++;
      end
      if (n < max_nexts)
         send_item(bvse_pkg::CMD_ITER_NEXT, $urandom_range(0, NumWords - 1), rand_word(),
                   rand_word(), rand_len());
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (tracker.due_results.size() != 0) @(posedge clock);
   endtask

   initial begin : rsp_ready_driver
      int unsigned burst;
      int unsigned held;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_holds_done < long_hold_requests) begin
            // hold off long enough for the engine to back up into the request side
            long_holds_done++;
            rsp_ch.ready <= 1'b0;
            for (held = 1; held < LongHold; held++) @(negedge clock);
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            burst = $urandom_range(1, 8);
            rsp_ch.ready <= 1'b0;
            repeat (burst - 1) @(negedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      set_result_type got;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got.read_data = rsp_ch.read_data;
         got.changed   = rsp_ch.changed;
         got.equal     = rsp_ch.equal;
         got.nonempty  = rsp_ch.nonempty;
         got.next_bit  = rsp_ch.next_bit;
         got.iter_done = rsp_ch.iter_done;
         tracker.check_result(got);
      end
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CycleLimit) begin
         @(posedge clock);
         cycles++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      logic [DataW-1:0] w;
      logic [LenW-1:0]  olen;
      logic [CmdW-1:0]  op;
      int unsigned      i;
      int unsigned      aw;
      int unsigned      first;
      int unsigned      last;
      int unsigned      start;
      int unsigned      ph;

      req_ch.valid        = 1'b0;
      req_ch.command      = bvse_pkg::CMD_READ;
      req_ch.word_index   = '0;
      req_ch.operand_word = '0;
      req_ch.kill_word    = '0;
      req_ch.other_length = LenReset;

      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Write every word first; a sparse set keeps the iterator walk short.
      for (i = 0; i < NumWords; i++) begin
         case (i)
            1:       w = WordOne;
            2:       w = WordOne << (WordBits - 1);
            9:       w = WordOne << 40;
            15:      w = (WordOne << (WordBits - 1)) | WordOne;
            default: w = '0;
         endcase
         send_item(bvse_pkg::CMD_LOAD, i, w, ~w, LenReset);
      end
      iter_walk(8);
      send_item(bvse_pkg::CMD_ITER_NEXT, 0, '0, '0, LenReset);
      send_item(bvse_pkg::CMD_UNION, 0, WordMask, '0, LenReset);
      send_item(bvse_pkg::CMD_UNION, 1, WordOne, '0, LenReset);
      send_item(bvse_pkg::CMD_GEN_KILL, 3, WordMask, {(DataW/4){4'h5}}, LenReset);
      send_item(bvse_pkg::CMD_DIFFERENCE, 3, WordMask, '0, LenReset);
      send_item(bvse_pkg::CMD_INTERSECT, 1, '0, WordMask, LenReset);
      send_item(bvse_pkg::CMD_COMPARE, 0, WordMask, '0, LenReset);
      send_item(bvse_pkg::CMD_COMPARE, 15, (WordOne << (WordBits - 1)) | WordOne, '0,
                LenW'(1));
      send_item(bvse_pkg::CMD_TEST_EMPTY, 0, '0, '0, LenReset);
      send_item(bvse_pkg::CMD_TEST_EMPTY, 3, '0, '0, LenReset);
      send_item(bvse_pkg::CMD_READ, 15, WordMask, WordMask, LenW'(MaxBits));
      send_item({CmdW{1'b1}}, 4, WordMask, WordMask, LenReset);

      for (ph = 0; ph < $size(phase_lengths); ph++) begin
         drain_results();
         @(negedge clock);
         csr_wr_en   <= 1'b1;
         csr_wr_data <= LenW'(phase_lengths[ph]);
         @(negedge clock);
         csr_wr_en <= 1'b0;
         tracker.length = phase_lengths[ph];
         idle_on = (ph != $size(phase_lengths) - 1);
         if (ph == 2) long_hold_requests++;

         start = items_sent;
         while (items_sent - start < PhaseItems) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: begin
                  // one operation swept over the words of the set, sometimes past its end
                  op = CmdW'($urandom_range(bvse_pkg::CMD_LOAD, bvse_pkg::CMD_TEST_EMPTY));
                  aw = tracker.active_words();
                  first = ($urandom_range(0, 3) == 0) ? $urandom_range(0, aw - 1) : 0;
                  last = ($urandom_range(0, 4) == 0) ? $urandom_range(aw - 1, NumWords - 1)
                                                     : aw - 1;
                  for (i = first; i <= last; i++) begin
                     w = rand_word();
                     olen = rand_len();
                     if (op == bvse_pkg::CMD_COMPARE && $urandom_range(0, 3) != 0) begin
                        w = tracker.words[i];
                        if ($urandom_range(0, 1) == 1)
                           w = w ^ (rand_word() & ~tracker.valid_mask(i));
                        if ($urandom_range(0, 7) == 0)
                           w = w ^ (WordOne << $urandom_range(0, WordBits - 1));
                        olen = ($urandom_range(0, 5) == 0) ? rand_len()
                                                           : LenW'(tracker.eff_length());
                     end
                     send_item(op, i, w, rand_word(), olen);
                  end
               end
               4: begin
                  for (i = $urandom_range(0, NumWords - 1); i < NumWords; i++)
                     send_item(bvse_pkg::CMD_READ, i, rand_word(), rand_word(), rand_len());
               end
               5, 6: iter_walk($urandom_range(1, 24));
               default: begin
                  repeat ($urandom_range(1, 4))
                     send_item(CmdW'($urandom_range(0, (1 << CmdW) - 1)),
                               $urandom_range(0, NumWords - 1), rand_word(), rand_word(),
                               rand_len());
               end
            endcase
         end
      end

      drain_results();
      repeat (TailCycles) @(posedge clock);
      if (tracker.due_results.size() != 0)
         tracker.flag_failure($sformatf("%0d results never arrived",
                                        tracker.due_results.size()));
      if (tracker.failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
